FILE: sv/i2seg_pkg.sv
// ----------------------------------------------------------------------------
// i2seg_pkg
// Shared types, constants and functions for the integer to seven-segment
// digit converter.
// ----------------------------------------------------------------------------
package i2seg_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int SEG_W      = 7;
	localparam int COL_W      = 4;
	localparam int STEPS_PER_STAGE = 8;

	localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
	localparam logic [SEG_W-1:0] SEG_ZERO  = 7'h3F;

	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dabble_t;

	function automatic logic [SEG_W-1:0] digit_font(input logic [3:0] d);
		logic [SEG_W-1:0] seg;
		unique case (d)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

	// Eight shift-and-add-3 steps of the double dabble conversion.
	function automatic dabble_t dabble_steps(input dabble_t d);
		dabble_t r;
		r = d;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				if (r.bcd[k*4 +: 4] >= 4'd5) begin
					r.bcd[k*4 +: 4] = r.bcd[k*4 +: 4] + 4'd3;
				end
			end
			r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
			r.bin = {r.bin[VALUE_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: sv/integer_to_seven_segment_digits_top.sv
// ----------------------------------------------------------------------------
// integer_to_seven_segment_digits_top
// Converts a signed 32-bit integer into a stream of seven-segment columns:
// an optional minus column, then the decimal digits, most significant first.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   value
//  output   out_valid / out_ready segments, is_sign, column, last
//
//  A request passes six pipeline stages (magnitude, four double dabble
//  stages of eight bits each, digit count and alignment) and then a column
//  sequencer that sends one column per cycle while out_ready is high, so a
//  request gives one to eleven columns at the output, and the sequencer sets the
//  sustained rate. The pipeline stages hold their requests during a stall.
//  Reset clears all valid bits and the sequencer.
// ----------------------------------------------------------------------------
module integer_to_seven_segment_digits_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  segments,
	output logic        is_sign,
	output logic [3:0]  column,
	output logic        last
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic                               neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [i2seg_pkg::VALUE_W-1:0]      mag_s1;
	i2seg_pkg::dabble_t                 dd_s2, dd_s3, dd_s4, dd_s5;
	logic [i2seg_pkg::BCD_W-1:0]        bcd_s6;
	logic [i2seg_pkg::COL_W-1:0]        ndig_s6;

	logic                               busy_q;
	logic                               neg_q;
	logic [i2seg_pkg::BCD_W-1:0]        bcd_q;
	logic [i2seg_pkg::COL_W-1:0]        ndig_q;
	logic [i2seg_pkg::COL_W-1:0]        col_q;

	logic                               out_fire;
	logic [i2seg_pkg::COL_W-1:0]        ncol;
	logic [i2seg_pkg::COL_W-1:0]        ndig_c;
	logic [i2seg_pkg::BCD_W-1:0]        bcd_align_c;

	assign out_fire = out_valid && out_ready;
	assign rdy_s6   = !busy_q || (out_fire && last);
	assign rdy_s5   = !vld_s6 || rdy_s6;
	assign rdy_s4   = !vld_s5 || rdy_s5;
	assign rdy_s3   = !vld_s4 || rdy_s4;
	assign rdy_s2   = !vld_s3 || rdy_s3;
	assign rdy_s1   = !vld_s2 || rdy_s2;
	assign in_ready = !vld_s1 || rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (rdy_s1)   vld_s2 <= vld_s1;
			if (rdy_s2)   vld_s3 <= vld_s2;
			if (rdy_s3)   vld_s4 <= vld_s3;
			if (rdy_s4)   vld_s5 <= vld_s4;
			if (rdy_s5)   vld_s6 <= vld_s5;
		end
	end

	// The most significant nonzero digit sets the digit count; zero keeps one digit.
	always_comb begin
		ndig_c = 4'd1;
		for (int k = 1; k < i2seg_pkg::NUM_DIGITS; k++) begin
			if (dd_s5.bcd[k*4 +: 4] != 4'd0) begin
				ndig_c = 4'(k + 1);
			end
		end
		bcd_align_c = dd_s5.bcd << {(4'(i2seg_pkg::NUM_DIGITS) - ndig_c), 2'b00};
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			neg_s1 <= value[31];
			mag_s1 <= value[31] ? (32'd0 - value) : value;
		end
		if (rdy_s1) begin
			neg_s2 <= neg_s1;
			dd_s2  <= i2seg_pkg::dabble_steps('{bcd: '0, bin: mag_s1});
		end
		if (rdy_s2) begin
			neg_s3 <= neg_s2;
			dd_s3  <= i2seg_pkg::dabble_steps(dd_s2);
		end
		if (rdy_s3) begin
			neg_s4 <= neg_s3;
			dd_s4  <= i2seg_pkg::dabble_steps(dd_s3);
		end
		if (rdy_s4) begin
			neg_s5 <= neg_s4;
			dd_s5  <= i2seg_pkg::dabble_steps(dd_s4);
		end
		if (rdy_s5) begin
			neg_s6  <= neg_s5;
			ndig_s6 <= ndig_c;
			bcd_s6  <= bcd_align_c;
		end
	end

	// Column sequencer: the leading digit always sits in the top nibble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (rdy_s6) begin
			busy_q <= vld_s6;
			col_q  <= '0;
		end else if (out_fire) begin
			col_q  <= col_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			neg_q  <= neg_s6;
			ndig_q <= ndig_s6;
			bcd_q  <= bcd_s6;
		end else if (out_fire && !is_sign) begin
			bcd_q  <= {bcd_q[i2seg_pkg::BCD_W-5:0], 4'd0};
		end
	end

	assign ncol      = ndig_q + {3'd0, neg_q};
	assign out_valid = busy_q;
	assign is_sign   = neg_q && (col_q == 4'd0);
	assign column    = col_q;
	assign last      = (col_q == ncol - 4'd1);
	assign segments  = is_sign ? i2seg_pkg::SEG_MINUS
	                           : i2seg_pkg::digit_font(bcd_q[i2seg_pkg::BCD_W-1 -: 4]);

endmodule

FILE: sv/i2seg_checker.sv
// ----------------------------------------------------------------------------
// i2seg_checker
// Port-level checks on the column stream of the seven-segment converter.
// ----------------------------------------------------------------------------
module i2seg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  segments,
	input logic        is_sign,
	input logic [3:0]  column,
	input logic        last
);

	// A waiting request keeps its value.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(value))
		else $error("input request changed while stalled");

	// A waiting column keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segments) && $stable(column)
		&& $stable(is_sign) && $stable(last))
		else $error("output column changed while stalled");

	// The columns of one request follow without gaps and count up.
	a_col_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && column == $past(column) + 4'd1)
		else $error("column sequence broken");

	// The minus column is the first one and never the last.
	a_sign_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_sign |-> column == 4'd0 && !last
		&& segments == i2seg_pkg::SEG_MINUS)
		else $error("bad minus column");

	// In column 0, a zero digit only appears for the value zero.
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_sign && column == 4'd0 && segments == i2seg_pkg::SEG_ZERO |-> last)
		else $error("leading zero digit");

endmodule

bind integer_to_seven_segment_digits_top i2seg_checker u_i2seg_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds signed integers into the seven-segment digit converter and checks
// every column that comes out against a column list worked out here from the
// decimal rendering of each accepted request. Both handshakes idle at random,
// and once the output side holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [i2seg_pkg::SEG_W-1:0] seg;
		logic                        sign;
		logic [i2seg_pkg::COL_W-1:0] col;
		logic                        last;
	} column_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [31:0]                 value = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [i2seg_pkg::SEG_W-1:0] segments;
	logic                        is_sign;
	logic [i2seg_pkg::COL_W-1:0] column;
	logic                        last;

	logic [31:0] pending_values[$];
	column_t     expected_columns[$];
	column_t     want;
	int          errors = 0;
	int          sent_count = 0;
	int          got_count = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          pause;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          idle_cycles = 0;

	integer_to_seven_segment_digits_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.segments  (segments),
		.is_sign   (is_sign),
		.column    (column),
		.last      (last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void predict_columns(input logic [31:0] v);
		logic [31:0]                 mag;
		logic [3:0]                  digs[10];
		logic [i2seg_pkg::SEG_W-1:0] glyph;
		column_t                     c;
		int                          n;
		int                          col;
		mag = v[31] ? (32'd0 - v) : v;
		n = 0;
		do begin
			digs[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0);
		col = 0;
		if (v[31]) begin
			c.seg  = i2seg_pkg::SEG_MINUS;
			c.sign = 1'b1;
			c.col  = '0;
			c.last = 1'b0;
			expected_columns.push_back(c);
			col++;
		end
		for (int i = n - 1; i >= 0; i--) begin
			case (digs[i])
				4'd0: glyph = 7'h3F;
				4'd1: glyph = 7'h06;
				4'd2: glyph = 7'h5B;
				4'd3: glyph = 7'h4F;
				4'd4: glyph = 7'h66;
				4'd5: glyph = 7'h6D;
				4'd6: glyph = 7'h7D;
				4'd7: glyph = 7'h07;
				4'd8: glyph = 7'h7F;
				default: glyph = 7'h6F;
			endcase
			c.seg  = glyph;
			c.sign = 1'b0;
			c.col  = col[i2seg_pkg::COL_W-1:0];
			c.last = (i == 0);
			expected_columns.push_back(c);
			col++;
		end
	endfunction

	function automatic logic [31:0] random_value();
		longint lo;
		longint hi;
		longint v;
		int     d;
		case ($urandom_range(0, 3))
			0: return $urandom;
			3: begin
				d = $urandom_range(0, 9);
				v = 1;
				for (int i = 0; i < d; i++) v = v * 10;
				if ($urandom_range(0, 1) == 1) v = v - 1;
			end
			default: begin
				d = $urandom_range(1, 10);
				lo = 1;
				for (int i = 1; i < d; i++) lo = lo * 10;
				hi = lo * 10 - 1;
				if (d == 1) lo = 0;
				if (hi > 64'd2147483648) hi = 64'd2147483648;
				v = lo + (longint'($urandom) % (hi - lo + 1));
			end
		endcase
		if ($urandom_range(0, 1) == 1) v = -v;
		return 32'(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			send_gap <= 0;
			sent_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_columns(value);
				void'(pending_values.pop_front());
				sent_count <= sent_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_values.size() != 0) begin
					in_valid <= 1'b1;
					value <= pending_values[0];
					send_gap <= ((sent_count % 50) < 12) ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_count >= 40) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			got_count <= 0;
		end else if (out_valid && out_ready) begin
			got_count <= got_count + 1;
			if (expected_columns.size() == 0) begin
				errors++;
				$display("%0t: expected no column, got seg=%h sign=%b col=%0d last=%b",
					$time, segments, is_sign, column, last);
			end else begin
				want = expected_columns.pop_front();
				if ({segments, is_sign, column, last} !== want) begin
					errors++;
					$display("%0t: expected seg=%h sign=%b col=%0d last=%b, got seg=%h sign=%b col=%0d last=%b",
						$time, want.seg, want.sign, want.col, want.last,
						segments, is_sign, column, last);
				end
			end
			pause = ((got_count % 90) < 20) ? 0 : $urandom_range(0, 3);
			recv_gap <= pause;
			out_ready <= (pause == 0) && (hold_left == 0);
		end else begin
			if (recv_gap != 0) recv_gap <= recv_gap - 1;
			out_ready <= (recv_gap <= 1) && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles == STALL_LIMIT) begin
					$display("integer_to_seven_segment_digits_top: mismatch");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd9, 32'd99,
			32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1234567890,
			-32'sd987654321, 32'd1000000000, 32'd999999999, -32'sd1000000000,
			32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, -32'sd10};
		repeat (136) pending_values.push_back(random_value());
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_values.size() != 0 || in_valid || expected_columns.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_columns.size() != 0) begin
			$display("%0t: expected %0d more columns, got none", $time,
				expected_columns.size());
		end
		if (errors == 0 && expected_columns.size() == 0) begin
			$display("integer_to_seven_segment_digits_top: match");
		end else begin
			$display("integer_to_seven_segment_digits_top: mismatch");
		end
		$finish;
	end

endmodule
